// ===== hw/rtl/linear_probe_hash_table_assert.svh =====
// Assertion macros for the hash table RTL.
// Depends on nothing; included by modules that carry checks.
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
// implication checked every clock outside reset
`define LPH_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// next-cycle implication
`define LPH_ASSERT_NXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

// ===== hw/rtl/lph_pkg.sv =====
// Types and constants for the linear probing hash table.
// No dependencies.
package lph_pkg;
  localparam int SLOT_COUNT_DEF = 256;
  localparam int KEY_BYTES_DEF  = 8;
  localparam int VALUE_BITS_DEF = 32;
  localparam logic [63:0] HASH_SEED = 64'd5381;
  localparam int HASH_SHIFT = 5;

  typedef enum logic [1:0] {OP_INSERT = 2'd0, OP_GET = 2'd1, OP_DELETE = 2'd2,
                            OP_NONE = 2'd3} op_t;
  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0, ST_UPDATED = 3'd1, ST_FULL = 3'd2, ST_HIT = 3'd3,
    ST_MISS = 3'd4, ST_DELETED = 3'd5, ST_DEL_NF = 3'd6
  } status_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] key;
    logic [31:0] value_in;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] read_value;
  } out_item_t;

  typedef enum logic [2:0] {FS_IDLE, FS_HASH, FS_MOD, FS_PUSH} front_state_t;
  typedef enum logic [2:0] {
    BS_CLEAR, BS_IDLE, BS_READ, BS_WAIT, BS_CHECK, BS_DONE
  } back_state_t;
endpackage

// ===== hw/rtl/linear_probe_hash_table.sv =====
// Top level of the linear probing hash table.
// Uses lph_pkg, lph_front, lph_back.
//   channel | handshake         | payload
//   in      | start / busy      | in_item (op, key, value_in)
//   out     | out_valid strobe  | out_item (status, read_value)
//   cfg     | cfg_we            | cfg_data (table_size)
// Front: hashes the key bytes (FS_HASH), reduces the hash modulo the table
// size (FS_MOD) and hands off (FS_PUSH). Back, per probed slot: address
// (BS_READ), registered RAM read (BS_WAIT), check (BS_CHECK); busy holds
// until the back takes the hashed request, so the front hashes the next key
// while the back probes. Reset is synchronous; the back then clears the slot
// state of every slot. The receiver cannot stall; each result strobes for
// one cycle.
module linear_probe_hash_table import lph_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int KEY_BYTES  = KEY_BYTES_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  logic [8:0] cfg_data
);
  localparam int IW = $clog2(SLOT_COUNT);
  logic [8:0] size_r;
  logic [IW:0] size;
  logic q_valid, q_ready;
  in_item_t q_item;
  logic [IW-1:0] q_home;

  always_ff @(posedge clk) begin
    if (!rst_n) size_r <= 9'd256;
    else if (cfg_we) size_r <= cfg_data;
  end
  // clamp before narrowing so large writes act as SLOT_COUNT
  assign size = (int'(size_r) > SLOT_COUNT) ? (IW+1)'(SLOT_COUNT) : (IW+1)'(size_r);

  lph_front #(.SLOT_COUNT(SLOT_COUNT), .KEY_BYTES(KEY_BYTES)) u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .size(size), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .q_home(q_home));
  lph_back #(.SLOT_COUNT(SLOT_COUNT), .VALUE_BITS(VALUE_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
    .q_item(q_item), .q_home(q_home), .size(size), .out_valid(out_valid),
    .out_item(out_item));
endmodule

// ===== hw/rtl/lph_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module lph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== hw/rtl/lph_front.sv =====
// Front end: canonicalizes the key, runs djb2 one byte a cycle, then reduces
// modulo the table size by restoring subtraction. Uses lph_pkg.
module lph_front import lph_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int KEY_BYTES  = KEY_BYTES_DEF,
  localparam int IW = $clog2(SLOT_COUNT)
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  in_item_t     in_item,
  input  logic [IW:0]  size,
  output logic         q_valid,
  input  logic         q_ready,
  output in_item_t     q_item,
  output logic [IW-1:0] q_home
);
  front_state_t st_r, st_nxt;
  in_item_t     item_r;
  logic [63:0]  kshift_r;
  logic [3:0]   cnt_r;
  logic         ended_r;
  logic [63:0]  h_r;
  logic [32:0]  rem_r;
  logic [5:0]   bit_r;
  logic [IW:0]  size_r;
  logic [7:0]   b;
  logic [33:0]  trial;

  assign b = kshift_r[7:0];
  assign busy = (st_r != FS_IDLE);
  assign q_valid = (st_r == FS_PUSH);
  assign q_item = item_r;
  assign q_home = rem_r[IW-1:0];
  assign trial = {rem_r, h_r[bit_r]} - {{(33-IW){1'b0}}, size_r};

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      FS_IDLE: if (start) st_nxt = FS_HASH;
      FS_HASH: if (cnt_r == 4'(KEY_BYTES - 1)) st_nxt = FS_MOD;
      FS_MOD:  if (bit_r == 6'd0) st_nxt = FS_PUSH;
      FS_PUSH: if (q_ready) st_nxt = FS_IDLE;
      default: st_nxt = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= FS_IDLE;
    else st_r <= st_nxt;
    unique case (st_r)
      FS_IDLE: if (start) begin
        item_r <= '{op: in_item.op, key: '0, value_in: in_item.value_in};
        kshift_r <= in_item.key;
        cnt_r <= '0;
        ended_r <= 1'b0;
        h_r <= HASH_SEED;
        size_r <= (size == '0) ? (IW+1)'(1) :
                  (size > (IW+1)'(SLOT_COUNT)) ? (IW+1)'(SLOT_COUNT) : size;
      end
      FS_HASH: begin
        // stop accumulating at the first zero byte
        if (!ended_r && b != 8'd0) begin
          h_r <= (h_r << HASH_SHIFT) + h_r + {56'd0, b};
          item_r.key[cnt_r[2:0]*8 +: 8] <= b;
        end else ended_r <= 1'b1;
        kshift_r <= kshift_r >> 8;
        cnt_r <= cnt_r + 4'd1;
        rem_r <= '0;
        bit_r <= 6'd63;
      end
      FS_MOD: begin
        // reduce the full 64-bit hash, one bit a cycle from the top
        if (!trial[33]) rem_r <= trial[32:0];
        else rem_r <= {rem_r[31:0], h_r[bit_r]};
        bit_r <= bit_r - 6'd1;
      end
      default: ;
    endcase
  end
endmodule

// ===== hw/rtl/lph_back.sv =====
// Back end: probes the slot memories one slot at a time and applies the
// operation; clears slot state after reset. Uses lph_pkg and lph_ram.
`include "linear_probe_hash_table_assert.svh"
module lph_back import lph_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  localparam int IW = $clog2(SLOT_COUNT)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_ready,
  input  in_item_t      q_item,
  input  logic [IW-1:0] q_home,
  input  logic [IW:0]   size,
  output logic          out_valid,
  output out_item_t     out_item
);
  // slot state: {occupied, tombstone}
  localparam logic [1:0] META_FREE = 2'b00;
  localparam logic [1:0] META_TOMB = 2'b01;
  localparam logic [1:0] META_LIVE = 2'b10;

  back_state_t st_r, st_nxt;
  in_item_t    item_r;
  logic [IW-1:0] idx_r, free_r, clr_r;
  logic [IW:0]  step_r, size_r;
  logic         have_free_r;
  logic         kwe, vwe, mwe;
  logic [1:0]   mwd, mrd;
  logic [IW-1:0] addr;
  logic [63:0]  krd;
  logic [VALUE_BITS-1:0] vrd, vwd;
  logic         occ, tomb, match, last;
  out_item_t    res_r;
  logic         res_v_r;

  assign vwd = VALUE_BITS'(item_r.value_in);
  lph_ram #(.WIDTH(64), .DEPTH(SLOT_COUNT)) u_key (
    .clk(clk), .we(kwe), .addr(addr), .wdata(item_r.key), .rdata(krd));
  lph_ram #(.WIDTH(VALUE_BITS), .DEPTH(SLOT_COUNT)) u_val (
    .clk(clk), .we(vwe), .addr(addr), .wdata(vwd), .rdata(vrd));
  lph_ram #(.WIDTH(2), .DEPTH(SLOT_COUNT)) u_meta (
    .clk(clk), .we(mwe), .addr(addr), .wdata(mwd), .rdata(mrd));

  assign occ = mrd[1];
  assign tomb = mrd[0];
  assign match = occ && !tomb && (krd == item_r.key);
  assign last = (step_r + (IW+1)'(1) >= size_r) || (!occ && !tomb);
  assign q_ready = (st_r == BS_IDLE);
  assign out_valid = res_v_r;
  assign out_item = res_r;

  always_comb begin
    st_nxt = st_r;
    kwe = 1'b0;
    vwe = 1'b0;
    mwe = 1'b0;
    mwd = META_FREE;
    addr = idx_r;
    unique case (st_r)
      BS_CLEAR: begin
        addr = clr_r;
        mwe = 1'b1;
        if (clr_r == IW'(SLOT_COUNT - 1)) st_nxt = BS_IDLE;
      end
      BS_IDLE: if (q_valid) st_nxt = (op_t'(q_item.op) == OP_NONE) ? BS_DONE : BS_READ;
      BS_READ: st_nxt = BS_WAIT;
      BS_WAIT: st_nxt = BS_CHECK;
      BS_CHECK: begin
        if (match) begin
          st_nxt = BS_IDLE;
          vwe = (op_t'(item_r.op) == OP_INSERT);
          if (op_t'(item_r.op) == OP_DELETE) begin
            mwe = 1'b1;
            mwd = META_TOMB;
          end
        end else if (last) begin
          st_nxt = BS_IDLE;
          if (op_t'(item_r.op) == OP_INSERT && (have_free_r || !occ || tomb)) begin
            addr = have_free_r ? free_r : idx_r;
            kwe = 1'b1;
            vwe = 1'b1;
            mwe = 1'b1;
            mwd = META_LIVE;
          end
        end else st_nxt = BS_READ;
      end
      BS_DONE: st_nxt = BS_IDLE;
      default: st_nxt = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BS_CLEAR;
      clr_r <= '0;
      res_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      res_v_r <= ((st_r == BS_CHECK) && (match || last)) || (st_r == BS_DONE);
      unique case (st_r)
        BS_CLEAR: clr_r <= clr_r + IW'(1);
        BS_IDLE: if (q_valid) begin
          item_r <= q_item;
          idx_r <= q_home;
          step_r <= '0;
          size_r <= (size == '0) ? (IW+1)'(1) :
                    (size > (IW+1)'(SLOT_COUNT)) ? (IW+1)'(SLOT_COUNT) : size;
          have_free_r <= 1'b0;
        end
        BS_CHECK: begin
          if (match) begin
            unique case (op_t'(item_r.op))
              OP_INSERT: begin
                res_r.status <= ST_UPDATED;
                res_r.read_value <= '0;
              end
              OP_GET: begin
                res_r.status <= ST_HIT;
                res_r.read_value <= 32'(vrd);
              end
              default: begin
                res_r.status <= ST_DELETED;
                res_r.read_value <= '0;
              end
            endcase
          end else if (last) begin
            res_r.read_value <= '0;
            unique case (op_t'(item_r.op))
              OP_INSERT: begin
                if (have_free_r || !occ || tomb) res_r.status <= ST_INSERTED;
                else res_r.status <= ST_FULL;
              end
              OP_GET: res_r.status <= ST_MISS;
              default: res_r.status <= ST_DEL_NF;
            endcase
          end else begin
            if (!have_free_r && (!occ || tomb)) begin
              have_free_r <= 1'b1;
              free_r <= idx_r;
            end
            step_r <= step_r + (IW+1)'(1);
            idx_r <= (idx_r + IW'(1) >= size_r[IW-1:0] && {1'b0, idx_r} + (IW+1)'(1) >= size_r)
                     ? '0 : idx_r + IW'(1);
          end
        end
        BS_DONE: begin
          res_r.status <= ST_MISS;
          res_r.read_value <= '0;
        end
        default: ;
      endcase
    end
  end

  `LPH_ASSERT_IMP(a_excl, clk, rst_n, 1'b1, !(kwe && st_r != BS_CHECK))
  `LPH_ASSERT_NXT(a_done, clk, rst_n, st_r == BS_DONE, res_v_r)
  `LPH_ASSERT_IMP(a_kv, clk, rst_n, kwe, vwe)
  `LPH_ASSERT_IMP(a_mwe, clk, rst_n, mwe, st_r == BS_CLEAR || st_r == BS_CHECK)
endmodule
